FILE: src/assert_macros.svh
// Assertion macros shared by the RTL files of the median deviation block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is asserted.
`define ASSERT_CLK(label, clock, rst_n, prop, msg) \
	label: assert property (@(posedge clock) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked assertion that also holds during reset.
`define ASSERT_ALWAYS(label, clock, prop, msg) \
	label: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

FILE: src/swmad_pkg.sv
// Shared types and fixed field widths of the sliding window median deviation block.
package swmad_pkg;

	localparam int SAMPLE_PORT_W = 32;
	localparam int MEDIAN_PORT_W = 32;
	localparam int DEV_W         = 37;
	localparam int COST_W        = 38;
	localparam int WS_W          = 7;
	localparam int WS_RESET_MAX  = 64;

	typedef struct packed {
		logic step;
		logic clear;
		logic pop;
	} win_ctl_t;

endpackage

FILE: src/swmad_window.sv
// Sorted window cell array with parallel removal of the oldest sample and sorted insert.
`include "assert_macros.svh"

module swmad_window
	import swmad_pkg::*;
#(
	parameter int WINDOW_MAX  = 64,
	parameter int SAMPLE_BITS = 32,
	parameter int LEN_W       = 7,
	parameter int AGE_W       = 6
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  win_ctl_t               ctl,
	input  logic [AGE_W-1:0]       pop_age,
	input  logic [SAMPLE_BITS-1:0] sample_in,
	output logic [LEN_W-1:0]       len,
	output logic [LEN_W-1:0]       add_len,
	output logic [SAMPLE_BITS-1:0] pop_val,
	output logic [SAMPLE_BITS-1:0] old_lo,
	output logic [SAMPLE_BITS-1:0] old_hi,
	output logic [SAMPLE_BITS-1:0] add_lo,
	output logic [SAMPLE_BITS-1:0] add_hi,
	output logic [SAMPLE_BITS-1:0] new_med
);

	localparam int IDX_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;

	logic [SAMPLE_BITS-1:0] val_q [WINDOW_MAX];
	logic [AGE_W-1:0]       age_q [WINDOW_MAX];
	logic [LEN_W-1:0]       len_q;

	logic [WINDOW_MAX-1:0]  match;
	logic [IDX_W-1:0]       rm_idx;
	logic                   rm_any;
	logic [SAMPLE_BITS-1:0] rem_val [WINDOW_MAX];
	logic [AGE_W-1:0]       rem_age [WINDOW_MAX];
	logic [WINDOW_MAX-1:0]  gt;
	logic [SAMPLE_BITS-1:0] new_val [WINDOW_MAX];
	logic [AGE_W-1:0]       new_age [WINDOW_MAX];
	logic [LEN_W-1:0]       na;
	logic [LEN_W-1:0]       lo_old, hi_old, lo_add, hi_add;

	// Ages are unique, so at most one cell holds the departing sample.
	always_comb begin
		rm_idx  = '0;
		pop_val = '0;
		for (int i = 0; i < WINDOW_MAX; i++) begin
			match[i] = ctl.pop && (LEN_W'(i) < len_q) && (age_q[i] == pop_age);
			if (match[i]) begin
				rm_idx  = rm_idx | IDX_W'(i);
				pop_val = pop_val | val_q[i];
			end
		end
		rm_any = |match;
	end

	always_comb begin
		for (int j = 0; j < WINDOW_MAX; j++) begin
			if (rm_any && (IDX_W'(j) >= rm_idx) && (j < WINDOW_MAX - 1)) begin
				rem_val[j] = val_q[(j + 1) % WINDOW_MAX];
				rem_age[j] = age_q[(j + 1) % WINDOW_MAX];
			end else begin
				rem_val[j] = val_q[j];
				rem_age[j] = age_q[j];
			end
		end
	end

	assign na = len_q - LEN_W'(rm_any);

	// Entries above the new sample move up one cell; empty cells count as larger.
	always_comb begin
		for (int i = 0; i < WINDOW_MAX; i++) begin
			gt[i] = (LEN_W'(i) >= na) || (rem_val[i] > sample_in);
		end
		for (int i = 0; i < WINDOW_MAX; i++) begin
			if (!gt[i]) begin
				new_val[i] = rem_val[i];
				new_age[i] = rem_age[i] + AGE_W'(1);
			end else if (i > 0 && gt[(i + WINDOW_MAX - 1) % WINDOW_MAX]) begin
				new_val[i] = rem_val[(i + WINDOW_MAX - 1) % WINDOW_MAX];
				new_age[i] = rem_age[(i + WINDOW_MAX - 1) % WINDOW_MAX] + AGE_W'(1);
			end else begin
				new_val[i] = sample_in;
				new_age[i] = '0;
			end
		end
	end

	assign lo_old = (len_q - LEN_W'(1)) >> 1;
	assign hi_old = len_q >> 1;
	assign lo_add = (na - LEN_W'(1)) >> 1;
	assign hi_add = na >> 1;

	assign old_lo  = val_q[lo_old[IDX_W-1:0]];
	assign old_hi  = val_q[hi_old[IDX_W-1:0]];
	assign add_lo  = rem_val[lo_add[IDX_W-1:0]];
	assign add_hi  = rem_val[hi_add[IDX_W-1:0]];
	assign new_med = new_val[hi_add[IDX_W-1:0]];
	assign len     = len_q;
	assign add_len = na;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
		end else if (ctl.clear) begin
			len_q <= '0;
		end else if (ctl.step) begin
			len_q <= na + LEN_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.step && !ctl.clear) begin
			for (int i = 0; i < WINDOW_MAX; i++) begin
				val_q[i] <= new_val[i];
				age_q[i] <= new_age[i];
			end
		end
	end

	`ASSERT_CLK(a_len_bound, clk, arst_n, int'(len_q) <= WINDOW_MAX, "window length exceeds capacity")
	`ASSERT_CLK(a_clear_len, clk, arst_n, $past(ctl.clear) |-> len_q == '0, "clear left entries")
	`ASSERT_CLK(a_pop_found, clk, arst_n, (ctl.step && ctl.pop) |-> rm_any, "oldest sample not found")

endmodule

FILE: src/sliding_window_median_abs_deviation.sv
// Top level of the sliding window median absolute deviation sum block.
// Each accepted sample passes an input register and is folded into the window, with its
// result written to the result register, once that register is free; a new sample is taken
// every cycle unless the receiver stalls. The rate is set by the sorted cell array,
// which removes the oldest sample and inserts the new one in a single parallel update.
// The first window_size - 1 samples after reset or a window_size write give no result.
// Writing window_size restarts the window; no clearing pass is needed.
`include "assert_macros.svh"

module sliding_window_median_abs_deviation
	import swmad_pkg::*;
#(
	parameter int WINDOW_MAX  = 64,
	parameter int SAMPLE_BITS = 32
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [WS_W-1:0]          cfg_wdata,
	input  logic                     sample_valid,
	output logic                     sample_ready,
	input  logic [SAMPLE_PORT_W-1:0] sample,
	output logic                     result_valid,
	input  logic                     result_ready,
	output logic [DEV_W-1:0]         deviation_sum,
	output logic [MEDIAN_PORT_W-1:0] median_value
);

	localparam int LEN_W  = $clog2(WINDOW_MAX + 1);
	localparam int AGE_W  = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
	localparam int WS_RST = (WINDOW_MAX < WS_RESET_MAX) ? WINDOW_MAX : WS_RESET_MAX;

	logic [LEN_W-1:0]         ws_q, fill_q, ws_new;
	logic [COST_W-1:0]        cost_q;
	logic [SAMPLE_BITS-1:0]   sample_s1;
	logic                     valid_s1;
	logic                     result_valid_q;
	logic [DEV_W-1:0]         dev_q;
	logic [MEDIAN_PORT_W-1:0] med_q;

	logic                     adv, full, produce;
	win_ctl_t                 ctl;
	logic [LEN_W-1:0]         len, na;
	logic [SAMPLE_BITS-1:0]   pop_val, old_lo, old_hi, add_lo, add_hi, new_med, hi_min;
	logic [COST_W-1:0]        c1, c2;

	assign adv          = valid_s1 && (!result_valid_q || result_ready);
	assign sample_ready = !valid_s1 || adv;
	assign full         = fill_q >= ws_q;
	assign produce      = full || ((fill_q + LEN_W'(1)) >= ws_q);

	assign ctl.step  = adv;
	assign ctl.clear = cfg_we;
	assign ctl.pop   = full;

	swmad_window #(
		.WINDOW_MAX (WINDOW_MAX),
		.SAMPLE_BITS(SAMPLE_BITS),
		.LEN_W      (LEN_W),
		.AGE_W      (AGE_W)
	) u_window (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl),
		.pop_age  (AGE_W'(ws_q - LEN_W'(1))),
		.sample_in(sample_s1),
		.len      (len),
		.add_len  (na),
		.pop_val  (pop_val),
		.old_lo   (old_lo),
		.old_hi   (old_hi),
		.add_lo   (add_lo),
		.add_hi   (add_hi),
		.new_med  (new_med)
	);

	assign hi_min = (sample_s1 < add_hi) ? sample_s1 : add_hi;

	// Leaving sample first, then the new one; each move corrects for the median shift.
	always_comb begin
		c1 = cost_q;
		if (full) begin
			if (pop_val >= old_lo) begin
				c1 = c1 - COST_W'(pop_val - old_lo);
			end else begin
				c1 = c1 - COST_W'(old_lo - pop_val);
			end
			if (!len[0] && (pop_val <= old_lo)) begin
				c1 = c1 - COST_W'(old_hi - old_lo);
			end
		end
		c2 = c1;
		if (na != '0) begin
			if (sample_s1 >= add_lo) begin
				c2 = c2 + COST_W'(sample_s1 - add_lo);
			end else begin
				c2 = c2 + COST_W'(add_lo - sample_s1);
			end
			if (!na[0] && (sample_s1 > add_lo)) begin
				c2 = c2 - COST_W'(hi_min - add_lo);
			end
		end
	end

	always_comb begin
		if (cfg_wdata == '0) begin
			ws_new = LEN_W'(1);
		end else if (int'(cfg_wdata) > WINDOW_MAX) begin
			ws_new = LEN_W'(WINDOW_MAX);
		end else begin
			ws_new = LEN_W'(cfg_wdata);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ws_q           <= LEN_W'(WS_RST);
			fill_q         <= '0;
			cost_q         <= '0;
			valid_s1       <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			if (sample_ready) begin
				valid_s1 <= sample_valid;
			end
			if (adv) begin
				result_valid_q <= produce;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				ws_q   <= ws_new;
				fill_q <= '0;
				cost_q <= '0;
			end else if (adv) begin
				cost_q <= c2;
				if (!full) begin
					fill_q <= fill_q + LEN_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (sample_ready && sample_valid) begin
			sample_s1 <= SAMPLE_BITS'(sample);
		end
		if (adv) begin
			dev_q <= c2[DEV_W-1:0];
			med_q <= MEDIAN_PORT_W'(new_med);
		end
	end

	assign result_valid  = result_valid_q;
	assign deviation_sum = dev_q;
	assign median_value  = med_q;

	`ASSERT_CLK(a_fill_bound, clk, arst_n, fill_q <= ws_q, "fill count beyond window size")
	`ASSERT_CLK(a_result_src, clk, arst_n, $rose(result_valid_q) |-> $past(adv), "result without item")
	`ASSERT_CLK(a_restart_cost, clk, arst_n, $past(cfg_we) |-> cost_q == '0, "restart kept cost")

endmodule

FILE: verif/sliding_window_median_abs_deviation_tb.sv
// Self-checking testbench for the sliding window median absolute deviation sum block.
`timescale 1ns / 1ps

module sliding_window_median_abs_deviation_tb;
	import swmad_pkg::*;

	localparam int WMAX      = 64;
	localparam int MAX_CYCLE = 2000000;

	logic                     clk;
	logic                     arst_n;
	logic                     cfg_we;
	logic [WS_W-1:0]          cfg_wdata;
	logic                     sample_valid;
	logic                     sample_ready;
	logic [SAMPLE_PORT_W-1:0] sample;
	logic                     result_valid;
	logic                     result_ready;
	logic [DEV_W-1:0]         deviation_sum;
	logic [MEDIAN_PORT_W-1:0] median_value;

	sliding_window_median_abs_deviation u_top (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.sample_valid(sample_valid), .sample_ready(sample_ready), .sample(sample),
		.result_valid(result_valid), .result_ready(result_ready),
		.deviation_sum(deviation_sum), .median_value(median_value)
	);

	typedef struct {
		logic [DEV_W-1:0]         dev;
		logic [MEDIAN_PORT_W-1:0] med;
	} mad_result_t;

	// Predictor state.
	logic [31:0]       line_mem [WMAX];
	logic [31:0]       sorted_mem [WMAX];
	int                fill_cnt;
	int                oldest;
	int                sorted_cnt;
	int                win_len;
	logic [COST_W-1:0] cost;

	logic [31:0]  sample_queue [$];
	mad_result_t  mad_queue [$];
	int           errors;
	int           cycle;
	int           results_seen;
	int           samples_sent;
	bit           hold_sink;
	bit           hold_source;
	int           src_gap;
	int           sink_gap;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic logic [31:0] absdiff(logic [31:0] a, logic [31:0] b);
		return (a >= b) ? a - b : b - a;
	endfunction

	function automatic logic [31:0] low_median();
		if (sorted_cnt == 0)
			return '0;
		return sorted_mem[(sorted_cnt - 1) / 2];
	endfunction

	task automatic sorted_add(logic [31:0] v);
		int i;
		if (sorted_cnt >= WMAX)
			sorted_cnt = WMAX - 1;
		i = sorted_cnt;
		while (i > 0 && sorted_mem[i-1] > v) begin
			sorted_mem[i] = sorted_mem[i-1];
			i--;
		end
		sorted_mem[i] = v;
		sorted_cnt++;
	endtask

	task automatic sorted_del(logic [31:0] v);
		int i;
		i = 0;
		while (i < sorted_cnt && sorted_mem[i] != v)
			i++;
		if (i >= sorted_cnt)
			return;
		while (i + 1 < sorted_cnt) begin
			sorted_mem[i] = sorted_mem[i+1];
			i++;
		end
		sorted_cnt--;
	endtask

	task automatic cost_enter(logic [31:0] v);
		int n;
		logic [31:0] m;
		n = sorted_cnt;
		if (n == 0) begin
			sorted_add(v);
			return;
		end
		m = low_median();
		cost = cost + COST_W'(absdiff(v, m));
		sorted_add(v);
		// An even count moves the lower median up when the new value lands above it.
		if ((n % 2) == 0 && v > m)
			cost = cost - COST_W'(sorted_mem[n/2] - m);
	endtask

	task automatic cost_leave(logic [31:0] v);
		int n;
		logic [31:0] m;
		n = sorted_cnt;
		if (n == 0)
			return;
		m = low_median();
		cost = cost - COST_W'(absdiff(v, m));
		sorted_del(v);
		if ((n % 2) == 0 && v <= m && sorted_cnt > 0)
			cost = cost - COST_W'(low_median() - m);
	endtask

	task automatic window_restart(logic [WS_W-1:0] value);
		int w;
		w = value;
		if (w < 1)
			w = 1;
		if (w > WMAX)
			w = WMAX;
		win_len = w;
		fill_cnt = 0;
		oldest = 0;
		cost = '0;
		sorted_cnt = 0;
	endtask

	task automatic predict_sample(logic [31:0] v);
		mad_result_t r;
		logic [31:0] old;
		if (fill_cnt < win_len) begin
			line_mem[fill_cnt] = v;
			cost_enter(v);
			fill_cnt++;
		end else begin
			old = line_mem[oldest];
			cost_leave(old);
			cost_enter(v);
			line_mem[oldest] = v;
			oldest = (oldest + 1 >= win_len) ? 0 : oldest + 1;
		end
		if (fill_cnt >= win_len) begin
			r.dev = cost[DEV_W-1:0];
			r.med = low_median();
			mad_queue = {mad_queue, r};
		end
	endtask

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		$display("mismatch %s at cycle %0d: got %0h expected %0h", what, cycle, got, want);
		errors++;
	endtask

	// Driver: one item from the pending queue at a time, random gaps between items.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_valid <= 1'b0;
			sample <= '0;
			src_gap <= 0;
		end else begin
			if (sample_valid && sample_ready) begin
				predict_sample(sample);
				samples_sent++;
			end
			if (sample_valid && !sample_ready) begin
				// Hold the item until it is accepted.
			end else if (src_gap > 0) begin
				sample_valid <= 1'b0;
				src_gap <= src_gap - 1;
			end else if (sample_queue.size() > 0 && !hold_source) begin
				sample_valid <= 1'b1;
				sample <= sample_queue.pop_front();
				src_gap <= ($urandom_range(0, 3) == 0) ?
					(($urandom_range(0, 15) == 0) ? $urandom_range(5, 30) :
					 $urandom_range(0, 2)) : 0;
			end else begin
				sample_valid <= 1'b0;
			end
		end
	end

	// Monitor and receiver stalls.
	always @(posedge clk or negedge arst_n) begin
		mad_result_t e;
		if (!arst_n) begin
			result_ready <= 1'b0;
			sink_gap <= 0;
		end else begin
			cycle++;
			if (result_valid && result_ready) begin
				results_seen++;
				if (mad_queue.size() == 0) begin
					report_mismatch("unexpected result", 64'(deviation_sum), 64'd0);
				end else begin
					e = mad_queue.pop_front();
					if (deviation_sum !== e.dev)
						report_mismatch("deviation_sum", 64'(deviation_sum), 64'(e.dev));
					if (median_value !== e.med)
						report_mismatch("median_value", 64'(median_value), 64'(e.med));
				end
			end
			if (hold_sink) begin
				result_ready <= 1'b0;
			end else if (sink_gap > 0) begin
				result_ready <= 1'b0;
				sink_gap <= sink_gap - 1;
			end else begin
				result_ready <= 1'b1;
				if ($urandom_range(0, 3) == 0)
					sink_gap <= ($urandom_range(0, 15) == 0) ? $urandom_range(5, 40) :
						$urandom_range(1, 2);
			end
			if (cycle > MAX_CYCLE) begin
				$display("timeout at cycle %0d", cycle);
				$display("FAILURE");
				$finish;
			end
		end
	end

	task automatic wait_drained();
		while (sample_queue.size() > 0 || sample_valid || mad_queue.size() > 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_window(logic [WS_W-1:0] value);
		wait_drained();
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_wdata = value;
		@(negedge clk);
		cfg_we = 1'b0;
		window_restart(value);
	endtask

	function automatic logic [31:0] rand_sample(int mode);
		case (mode)
			0: return $urandom;
			1: return $urandom_range(0, 15);
			2: return 32'hFFFF_FFF0 | $urandom_range(0, 15);
			default: return ($urandom_range(0, 1) != 0) ? 32'hFFFF_FFFF : 32'h0;
		endcase
	endfunction

	task automatic queue_random(int count);
		int mode;
		mode = $urandom_range(0, 3);
		repeat (count) begin
			if ($urandom_range(0, 9) == 0)
				mode = $urandom_range(0, 3);
			sample_queue = {sample_queue, rand_sample(mode)};
		end
	endtask

	initial begin
		logic [WS_W-1:0] sizes [] = '{7'd0, 7'd1, 7'd2, 7'd3, 7'd5, 7'd8, 7'd17,
			7'd64, 7'd65, 7'd127};
		errors = 0;
		cycle = 0;
		results_seen = 0;
		samples_sent = 0;
		hold_sink = 1'b0;
		hold_source = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		arst_n = 1'b0;
		window_restart(WS_W'(WS_RESET_MAX));
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: reset window size, extremes and repeated values.
		for (int i = 0; i < 20; i++)
			sample_queue = {sample_queue,
				((i % 3 == 0) ? 32'hFFFF_FFFF : (i % 3 == 1) ? 32'h0 : 32'h5)};
		write_window(7'd0);
		sample_queue = {sample_queue, 32'hFFFF_FFFF};
		sample_queue = {sample_queue, 32'h0};
		write_window(7'd127);
		queue_random(66);

		// Receiver holds off while the sender keeps offering items.
		wait_drained();
		hold_sink = 1'b1;
		queue_random(30);
		repeat (200) @(posedge clk);
		hold_sink = 1'b0;

		// Sender pauses until every result has come.
		hold_source = 1'b1;
		queue_random(5);
		while (mad_queue.size() > 0) @(posedge clk);
		hold_source = 1'b0;

		for (int p = 0; p < 16; p++) begin
			write_window(sizes[$urandom_range(0, sizes.size() - 1)]);
			queue_random(45);
		end
		write_window(7'd1);
		queue_random(20);
		write_window(7'd64);
		queue_random(90);

		wait_drained();
		repeat (20) @(posedge clk);
		$display("Sent %0d samples over window sizes 0 through 127, checked %0d results,",
			samples_sent, results_seen);
		$display("with random stalls on both sides and a long receiver hold-off.");
		if (errors == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule

FILE: sliding_window_median_abs_deviation.f
+incdir+src
src/swmad_pkg.sv
src/swmad_window.sv
src/sliding_window_median_abs_deviation.sv
verif/sliding_window_median_abs_deviation_tb.sv
